// File: design/mexp_pkg.sv
package mexp_pkg;

	// Width of the item fields on the channels
	localparam int FIELD_W = 32;

	// Working width of the datapath; operands are masked or zero-extended to it
	localparam int OW = 32;

	// Staging width for moving values between field and working width
	localparam int WIDE_W = 64;

	// Bit counter for the base reduction, able to hold OW itself
	localparam int CNT_W = $clog2(OW + 1);

	// Command from the sequencer to the shared multiply-reduce unit
	typedef struct packed {
		logic start;
		logic reduce;
	} mmu_ctrl_t;

	// Fit a field value to the working width
	function automatic logic [OW-1:0] to_opnd(logic [FIELD_W-1:0] x);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(x);
		return w[OW-1:0];
	endfunction

	// Fit a working value back to the field width
	function automatic logic [FIELD_W-1:0] to_field(logic [OW-1:0] x);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(x);
		return w[FIELD_W-1:0];
	endfunction

endpackage

// File: design/mexp_if.sv
// Request channel: base, exponent, modulus
interface mexp_in_if;
	import mexp_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] base;
	logic [FIELD_W-1:0] exponent;
	logic [FIELD_W-1:0] modulus;

	modport source (output valid, output base, output exponent, output modulus, input ready);
	modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

// Response channel: result and zero-modulus flag
interface mexp_out_if;
	import mexp_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] result;
	logic               mod_zero_error;

	modport source (output valid, output result, output mod_zero_error, input ready);
	modport sink   (input valid, input result, input mod_zero_error, output ready);
endinterface

// File: design/mexp_mulmod.sv
module mexp_mulmod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mexp_pkg::mmu_ctrl_t      ctrl,
	input  logic [mexp_pkg::OW-1:0]  a_in,
	input  logic [mexp_pkg::OW-1:0]  b_in,
	input  logic [mexp_pkg::OW-1:0]  m_in,
	output logic                     done,
	output logic [mexp_pkg::OW-1:0]  product
);
	import mexp_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic             reduce_q;
	logic [OW-1:0]    a_q;
	logic [OW-1:0]    b_q;
	logic [OW-1:0]    acc_q;
	logic [OW-1:0]    m_q;
	logic [CNT_W-1:0] cnt_q;

	logic [OW:0]   a_dbl;
	logic [OW-1:0] a_next;
	logic [OW:0]   acc_sum;
	logic [OW-1:0] acc_next;
	logic          finish;

	// Double the running addend, shifting in the next base bit when reducing
	always_comb begin
		a_dbl = {1'b0, a_q} + {1'b0, a_q} + (OW+1)'(reduce_q & b_q[OW-1]);
		if (a_dbl >= {1'b0, m_q}) begin
			a_next = OW'(a_dbl - {1'b0, m_q});
		end else begin
			a_next = a_dbl[OW-1:0];
		end
	end

	// Add the addend into the accumulator modulo m
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, a_q};
		if (acc_sum >= {1'b0, m_q}) begin
			acc_next = OW'(acc_sum - {1'b0, m_q});
		end else begin
			acc_next = acc_sum[OW-1:0];
		end
	end

	// Stop when the multiplier runs out of set bits, or all base bits are in
	assign finish = reduce_q ? (cnt_q == '0) : (b_q == '0);

	// Control: busy flag and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			reduce_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q   <= 1'b1;
				reduce_q <= ctrl.reduce;
			end else if (busy_q && finish) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: one multiplier bit or one base bit per cycle
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q   <= ctrl.reduce ? '0 : a_in;
			b_q   <= b_in;
			acc_q <= '0;
			m_q   <= m_in;
			cnt_q <= CNT_W'(OW);
		end else if (busy_q && !finish) begin
			a_q <= a_next;
			if (reduce_q) begin
				b_q   <= b_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end else begin
				if (b_q[0]) begin
					acc_q <= acc_next;
				end
				b_q <= b_q >> 1;
			end
		end
	end

	assign done    = done_q;
	assign product = reduce_q ? a_q : acc_q;

endmodule

// File: design/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply: for each request
// beat (base, exponent, modulus) one response beat carries base^exponent mod
// modulus. A zero modulus returns 0 with mod_zero_error set; a zero exponent
// returns 1 unreduced. One request is in flight at a time and the request side
// is not ready while it runs. All work goes through one shared multiply-reduce
// unit that retires one bit per cycle: first the base is reduced, then each
// exponent bit below the highest set one costs a squaring plus, when the bit
// is set, a multiply, and the highest set bit costs a multiply only. The
// finished result sits in an output register, so the next request is taken
// while the previous response waits.
module modular_exponentiation (
	input  logic              clk,
	input  logic              arst_n,
	mexp_in_if.sink           req,
	mexp_out_if.source        rsp
);
	import mexp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REDUCE = 6'b000010,
		ST_BIT    = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_SQR    = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t        state_q;
	state_t        state_d;

	logic [OW-1:0] base_q;
	logic [OW-1:0] e_q;
	logic [OW-1:0] m_q;
	logic [OW-1:0] acc_q;
	logic          err_q;

	logic               rsp_valid_q;
	logic [FIELD_W-1:0] result_q;
	logic               rsp_err_q;

	mmu_ctrl_t     mmu_ctrl;
	logic [OW-1:0] mmu_a;
	logic [OW-1:0] mmu_b;
	logic [OW-1:0] mmu_m;
	logic          mmu_done;
	logic [OW-1:0] mmu_product;

	logic          req_beat;
	logic [OW-1:0] req_base;
	logic [OW-1:0] req_exp;
	logic [OW-1:0] req_mod;
	logic          slot_free;
	logic          e_last;

	assign req_beat  = req.valid && req.ready;
	assign req_base  = to_opnd(req.base);
	assign req_exp   = to_opnd(req.exponent);
	assign req_mod   = to_opnd(req.modulus);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign e_last    = (e_q[OW-1:1] == '0);

	mexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mmu_ctrl),
		.a_in    (mmu_a),
		.b_in    (mmu_b),
		.m_in    (mmu_m),
		.done    (mmu_done),
		.product (mmu_product)
	);

	// Sequence the reduction, multiplies and squarings on the shared unit
	always_comb begin
		state_d         = state_q;
		mmu_ctrl.start  = 1'b0;
		mmu_ctrl.reduce = 1'b0;
		mmu_a           = base_q;
		mmu_b           = base_q;
		mmu_m           = m_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_beat) begin
					if (req_mod == '0) begin
						state_d = ST_FINISH;
					end else begin
						mmu_ctrl.start  = 1'b1;
						mmu_ctrl.reduce = 1'b1;
						mmu_b           = req_base;
						mmu_m           = req_mod;
						state_d         = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mmu_done) begin
					state_d = ST_BIT;
				end
			end
			ST_BIT: begin
				if (e_q == '0) begin
					state_d = ST_FINISH;
				end else if (e_q[0]) begin
					mmu_ctrl.start = 1'b1;
					mmu_a          = acc_q;
					state_d        = ST_MUL;
				end else begin
					mmu_ctrl.start = 1'b1;
					state_d        = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mmu_done) begin
					if (e_last) begin
						state_d = ST_FINISH;
					end else begin
						mmu_ctrl.start = 1'b1;
						state_d        = ST_SQR;
					end
				end
			end
			ST_SQR: begin
				if (mmu_done) begin
					state_d = ST_BIT;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the operands and fold in each product from the shared unit
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_beat) begin
			e_q   <= req_exp;
			m_q   <= req_mod;
			acc_q <= (req_mod == '0) ? '0 : OW'(1);
			err_q <= (req_mod == '0);
		end else if (mmu_done) begin
			if (state_q == ST_REDUCE) begin
				base_q <= mmu_product;
			end else if (state_q == ST_MUL) begin
				acc_q <= mmu_product;
				if (e_last) begin
					e_q <= '0;
				end
			end else if (state_q == ST_SQR) begin
				base_q <= mmu_product;
				e_q    <= e_q >> 1;
			end
		end
	end

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && slot_free) begin
			result_q  <= to_field(acc_q);
			rsp_err_q <= err_q;
		end
	end

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.result         = result_q;
	assign rsp.mod_zero_error = rsp_err_q;

endmodule

// File: design/mexp_checker.sv
module mexp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [mexp_pkg::FIELD_W-1:0] rsp_result,
	input logic                         rsp_mod_zero_error
);
	import mexp_pkg::*;

	logic [1:0] pending_q;
	logic       req_beat;
	logic       rsp_beat;

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	// Track beats taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (req_beat && !rsp_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_beat && !req_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// A stalled response holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
			&& $stable(rsp_mod_zero_error))
		else $error("response changed while stalled");

	// Only one request at a time: busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |=> !req_ready)
		else $error("request side ready while a request is in flight");

	// A zero-modulus response carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_mod_zero_error |-> rsp_result == '0)
		else $error("zero-modulus response with nonzero result");

	// No response without an outstanding request
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("response without a request");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_result         (rsp.result),
	.rsp_mod_zero_error (rsp.mod_zero_error)
);
